// ----- rtl/dvfe_pkg.sv -----
// ----------------------------------------------------------------------------
// dvfe_pkg
// Shared types and constants of the delta varint frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dvfe_pkg;

	// configuration register indexes
	localparam logic [7:0] REG_DELTA_ORDER   = 8'd0;
	localparam logic [7:0] REG_FRAME_LENGTH  = 8'd1;
	localparam logic [7:0] REG_TYPE_BYTE     = 8'd2;
	localparam logic [7:0] REG_UNSIGNED_MODE = 8'd3;

	localparam logic [1:0] ORDER_DOD = 2'd2;

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// bytes per command kind
	localparam logic [3:0] LEN_ERR = 4'd1;
	localparam logic [3:0] LEN_HDR = 4'd12;
	localparam logic [3:0] LEN_RAW = 4'd4;

	typedef enum logic [1:0] {
		KIND_ERR,
		KIND_HDR,
		KIND_RAW,
		KIND_VAR
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;   // sample, raw delta or zigzag code
		logic [3:0]  len;     // bytes to send
		logic        eof;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  delta_order;
		logic [15:0] frame_length;
		logic [7:0]  type_byte;
		logic        unsigned_mode;
	} cfg_t;

endpackage

`default_nettype wire

// ----- rtl/dvfe_front.sv -----
// ----------------------------------------------------------------------------
// dvfe_front
// Config registers, sample acceptance, frame position and delta computation.
// ----------------------------------------------------------------------------
`default_nettype none

module dvfe_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [7:0]     cfg_index,
	input  wire logic [15:0]    cfg_data,
	input  wire logic           s_axis_tvalid,
	output logic                s_axis_tready,
	input  wire logic [31:0]    s_axis_tdata,
	output dvfe_pkg::cfg_t      cfg,
	output logic                push_valid,
	input  wire logic           push_ready,
	output dvfe_pkg::cmd_t      push_cmd
);
	import dvfe_pkg::*;

	cfg_t        cfg_q;
	logic [15:0] idx_q;
	logic [31:0] prev_q;
	logic [31:0] pd_q;

	logic        v_s1;
	kind_t       kind_s1;
	logic [31:0] samp_s1;
	logic [31:0] prev_s1;
	logic        eof_s1;
	logic        dd_s1;

	logic        accept;
	logic        err;
	logic [16:0] nxt;
	logic [16:0] limit;
	logic        hit;
	kind_t       kind_in;

	logic [31:0] d;
	logic [31:0] dd;
	logic [31:0] vin;
	logic [31:0] z;
	logic [3:0]  vlen;

	assign cfg_ready     = 1'b1;
	assign cfg           = cfg_q;
	assign s_axis_tready = !v_s1 || push_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		err   = cfg_q.unsigned_mode && s_axis_tdata[31];
		nxt   = {1'b0, idx_q} + 17'd1;
		limit = (cfg_q.frame_length == 16'd0) ? 17'h10000 : {1'b0, cfg_q.frame_length};
		hit   = nxt >= limit;
		if (err) begin
			kind_in = KIND_ERR;
		end else if (idx_q == 16'd0) begin
			kind_in = KIND_HDR;
		end else if (cfg_q.delta_order == ORDER_DOD && idx_q == 16'd1) begin
			kind_in = KIND_RAW;
		end else begin
			kind_in = KIND_VAR;
		end
	end

	// second half: deltas and zigzag code
	always_comb begin
		d   = samp_s1 - prev_s1;
		dd  = d - pd_q;
		vin = dd_s1 ? dd : d;
		z   = {vin[30:0], 1'b0} ^ {32{vin[31]}};
		if (z[31:28] != 4'd0) begin
			vlen = 4'd5;
		end else if (z[27:21] != 7'd0) begin
			vlen = 4'd4;
		end else if (z[20:14] != 7'd0) begin
			vlen = 4'd3;
		end else if (z[13:7] != 7'd0) begin
			vlen = 4'd2;
		end else begin
			vlen = 4'd1;
		end
		push_cmd.kind = kind_s1;
		push_cmd.eof  = eof_s1;
		unique case (kind_s1)
			KIND_ERR: begin
				push_cmd.value = 32'd0;
				push_cmd.len   = LEN_ERR;
			end
			KIND_HDR: begin
				push_cmd.value = samp_s1;
				push_cmd.len   = LEN_HDR;
			end
			KIND_RAW: begin
				push_cmd.value = d;
				push_cmd.len   = LEN_RAW;
			end
			default: begin
				push_cmd.value = z;
				push_cmd.len   = vlen;
			end
		endcase
	end

	assign push_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delta_order   <= 2'd1;
			cfg_q.frame_length  <= 16'd1;
			cfg_q.type_byte     <= 8'd0;
			cfg_q.unsigned_mode <= 1'b0;
			idx_q               <= 16'd0;
			prev_q              <= 32'd0;
			pd_q                <= 32'd0;
			v_s1                <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_DELTA_ORDER:   cfg_q.delta_order   <= cfg_data[1:0];
					REG_FRAME_LENGTH:  cfg_q.frame_length  <= cfg_data;
					REG_TYPE_BYTE:     cfg_q.type_byte     <= cfg_data[7:0];
					REG_UNSIGNED_MODE: cfg_q.unsigned_mode <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept) begin
				if (err) begin
					idx_q <= 16'd0;
				end else begin
					idx_q  <= hit ? 16'd0 : nxt[15:0];
					prev_q <= s_axis_tdata;
				end
				v_s1 <= 1'b1;
			end else if (push_ready) begin
				v_s1 <= 1'b0;
			end
			if (v_s1 && push_ready) begin
				if (kind_s1 == KIND_HDR) begin
					pd_q <= 32'd0;
				end else if (kind_s1 != KIND_ERR) begin
					pd_q <= d;
				end
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind_in;
			samp_s1 <= s_axis_tdata;
			prev_s1 <= prev_q;
			eof_s1  <= !err && hit;
			dd_s1   <= cfg_q.delta_order == ORDER_DOD;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dvfe_queue.sv -----
// ----------------------------------------------------------------------------
// dvfe_queue
// Small command FIFO between the front and the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module dvfe_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire dvfe_pkg::cmd_t push_cmd,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output dvfe_pkg::cmd_t      pop_cmd
);
	import dvfe_pkg::*;

	cmd_t           mem [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           push;
	logic           pop;

	assign push_ready = cnt_q != QDEPTH[QAW:0];
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QDEPTH[QAW:0])
		else $error("queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == QDEPTH[QAW:0]) |-> wr_q == rd_q)
		else $error("queue pointers out of step with count");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a push");

endmodule

`default_nettype wire

// ----- rtl/dvfe_back.sv -----
// ----------------------------------------------------------------------------
// dvfe_back
// Byte serializer: turns one command into its header, raw, varint or error bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module dvfe_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire dvfe_pkg::cfg_t cfg,
	input  wire logic           pop_valid,
	output logic                pop_ready,
	input  wire dvfe_pkg::cmd_t pop_cmd,
	output logic                m_axis_tvalid,
	input  wire logic           m_axis_tready,
	output logic [7:0]          m_axis_tdata,
	output logic                m_axis_tlast,
	output logic [1:0]          m_axis_tuser
);
	import dvfe_pkg::*;

	cmd_t       cmd_q;
	logic [3:0] cnt_q;
	logic       busy_q;
	logic       slot_free;
	logic       issue;
	logic       is_last;
	logic       load;
	logic [7:0] vbyte;
	logic [7:0] rbyte;
	logic [7:0] obyte;

	assign slot_free = !m_axis_tvalid || m_axis_tready;
	assign issue     = busy_q && slot_free;
	assign is_last   = cnt_q == cmd_q.len - 4'd1;
	assign pop_ready = !busy_q || (issue && is_last);
	assign load      = pop_valid && pop_ready;

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    rbyte = cmd_q.value[7:0];
			2'd1:    rbyte = cmd_q.value[15:8];
			2'd2:    rbyte = cmd_q.value[23:16];
			default: rbyte = cmd_q.value[31:24];
		endcase
		// seven payload bits per byte, continuation flag on top
		case (cnt_q[2:0])
			3'd0:    vbyte = {!is_last, cmd_q.value[6:0]};
			3'd1:    vbyte = {!is_last, cmd_q.value[13:7]};
			3'd2:    vbyte = {!is_last, cmd_q.value[20:14]};
			3'd3:    vbyte = {!is_last, cmd_q.value[27:21]};
			default: vbyte = {4'd0, cmd_q.value[31:28]};
		endcase
		unique case (cmd_q.kind)
			KIND_ERR: obyte = 8'd0;
			KIND_HDR: begin
				case (cnt_q)
					4'd0:    obyte = cfg.type_byte;
					4'd1:    obyte = {6'd0, cfg.delta_order};
					4'd2:    obyte = cfg.frame_length[7:0];
					4'd3:    obyte = cfg.frame_length[15:8];
					4'd8, 4'd9, 4'd10, 4'd11: obyte = rbyte;
					default: obyte = 8'd0;
				endcase
			end
			KIND_RAW: obyte = rbyte;
			default:  obyte = vbyte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (issue && is_last) begin
				busy_q <= 1'b0;
			end
			if (issue) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= pop_cmd;
			cnt_q <= 4'd0;
		end else if (issue) begin
			cnt_q <= cnt_q + 4'd1;
		end
		if (issue) begin
			m_axis_tdata    <= obyte;
			m_axis_tlast    <= is_last;
			m_axis_tuser[0] <= is_last && cmd_q.eof;
			m_axis_tuser[1] <= cmd_q.kind == KIND_ERR;
		end
	end

	a_cnt_in_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q < cmd_q.len)
		else $error("byte counter ran past command length");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
		else $error("end of frame away from last byte of sample");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]))
		else $error("error word malformed");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !issue) |=> $stable(cnt_q))
		else $error("byte counter moved without a byte");

endmodule

`default_nettype wire

// ----- rtl/delta_varint_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// delta_varint_frame_encoder
// Frames 32-bit samples into header + raw sample, then delta or
// delta-of-delta zigzag varints, one byte per output word.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  --------  ---  ---------------------  ------------------------------------
//  cfg       in   cfg_valid/cfg_ready    cfg_index register, cfg_data value
//  s_axis    in   tvalid/tready          tdata = sample_value[31:0]
//  m_axis    out  tvalid/tready          tdata = out_byte, tlast = last_of_run,
//                                        tuser = {range_error, end_of_frame}
//
//  Each sample produces 1 to 12 bytes: 12 for a frame start, 4 for the raw
//  first delta in order 2, 1 to 5 for a varint, 1 for a range error. The
//  output side moves one byte per cycle while the sink is ready; a four-deep
//  command queue lets samples be taken while the serializer is still busy.
//  Each sample passes the front stage, a queue slot and the command register.
//  Reset clears the frame position, both delta histories and the registers
//  (order 1, length 1, type 0, signed). Either side may stall at any time.
//  cfg_ready is always high; writes belong only to idle periods.
//
`default_nettype none

module delta_varint_frame_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] sample_value
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
	output logic             m_axis_tlast,   // last_of_run
	output logic [1:0]       m_axis_tuser    // [0] end_of_frame, [1] range_error
);
	import dvfe_pkg::*;

	cfg_t cfg;
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	// front: registers, frame tracking, deltas
	dvfe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cfg           (cfg),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_cmd      (push_cmd)
	);

	// decoupling queue
	dvfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// back: byte serializer with output register
	dvfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_cmd       (pop_cmd),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the delta varint frame encoder. Samples go in on the
// slave stream while registers are changed only between quiet periods. A
// bit-accurate predictor turns every accepted sample into the bytes it should
// produce: headers, raw words, zigzag varints and range errors. Every byte
// that leaves the master stream is compared against them in order. Directed
// cases come first, then random frames under several idle and stall mixes.
// ----------------------------------------------------------------------------

module tb_top;
	import dvfe_pkg::*;

	// plain order and the two codes that fall back to it
	localparam logic [1:0] ORDER_PLAIN = 2'd1;
	localparam logic [1:0] ORDER_ZERO  = 2'd0;
	localparam logic [1:0] ORDER_THREE = 2'd3;
	// first register index the block does not decode
	localparam logic [7:0] REG_FIRST_SPARE = 8'd4;

	localparam int QUIET_LIMIT    = 4000;      // cycles with no word moving
	localparam int MAX_RUN_CYCLES = 1000000;
	localparam int SETTLE_CYCLES  = 8;         // longer than the input-to-output latency
	localparam int MAX_PRINTS     = 40;

	// one output word as the predictor expects it
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       eof;
		logic       err;
	} coded_byte_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [31:0] sample_value
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // [7:0] out_byte
	logic        m_axis_tlast;   // last_of_run
	logic [1:0]  m_axis_tuser;   // [0] end_of_frame, [1] range_error

	// predictor state: registers as written, frame position, delta history
	cfg_t        enc_cfg;
	logic [31:0] prev_sample;
	logic [31:0] last_delta;
	logic [15:0] frame_pos;
	logic [7:0]  run_bytes[$];       // bytes of the sample being predicted
	coded_byte_t pending_bytes[$];   // expected output words, oldest first
	coded_byte_t want;

	int src_idle_pct;
	int sink_stall_pct;
	int mismatches;
	int out_count;
	int quiet_cycles;
	int run_cycles;

	delta_varint_frame_encoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// starts low so the first rising edge comes after time zero
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	task automatic add_raw32(input logic [31:0] v);
		run_bytes.push_back(v[7:0]);
		run_bytes.push_back(v[15:8]);
		run_bytes.push_back(v[23:16]);
		run_bytes.push_back(v[31:24]);
	endtask

	// zigzag, then LEB128: seven bits per byte, bit 7 set on all but the last
	task automatic add_varint(input logic [31:0] d);
		logic [31:0] z;
		z = {d[30:0], 1'b0} ^ {32{d[31]}};
		while (z >= 32'h80) begin
			run_bytes.push_back({1'b1, z[6:0]});
			z = z >> 7;
		end
		run_bytes.push_back(z[7:0]);
	endtask

	task automatic encode_sample(input logic [31:0] s);
		logic [31:0] d;
		logic [16:0] limit;
		logic [16:0] next_pos;
		logic        frame_done;
		coded_byte_t cb;
		run_bytes.delete();
		if (enc_cfg.unsigned_mode && s[31]) begin
			// rejected sample: one error word, frame thrown away
			cb = '{data: 8'h00, last: 1'b1, eof: 1'b0, err: 1'b1};
			pending_bytes.push_back(cb);
			frame_pos = '0;
		end else begin
			if (frame_pos == 16'd0) begin
				run_bytes.push_back(enc_cfg.type_byte);
				run_bytes.push_back({6'd0, enc_cfg.delta_order});
				run_bytes.push_back(enc_cfg.frame_length[7:0]);
				run_bytes.push_back(enc_cfg.frame_length[15:8]);
				add_raw32(32'd0);          // scale slot, always zero here
				add_raw32(s);
				last_delta = '0;
			end else begin
				d = s - prev_sample;
				if (enc_cfg.delta_order == ORDER_DOD) begin
					if (frame_pos == 16'd1)
						add_raw32(d);
					else
						add_varint(d - last_delta);
				end else begin
					add_varint(d);
				end
				last_delta = d;
			end
			prev_sample = s;
			// length 0 means 65536; a lowered length ends the frame at once
			limit      = (enc_cfg.frame_length == 16'd0) ? 17'h10000 : {1'b0, enc_cfg.frame_length};
			next_pos   = {1'b0, frame_pos} + 17'd1;
			frame_done = (next_pos >= limit);
			frame_pos  = frame_done ? 16'd0 : next_pos[15:0];
			foreach (run_bytes[i]) begin
				cb.data = run_bytes[i];
				cb.last = (i == run_bytes.size() - 1);
				cb.eof  = cb.last && frame_done;
				cb.err  = 1'b0;
				pending_bytes.push_back(cb);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// leaves cfg_valid high so back-to-back writes need no second assignment
	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DELTA_ORDER:   enc_cfg.delta_order   = val[1:0];
			REG_FRAME_LENGTH:  enc_cfg.frame_length  = val;
			REG_TYPE_BYTE:     enc_cfg.type_byte     = val[7:0];
			REG_UNSIGNED_MODE: enc_cfg.unsigned_mode = val[0];
			default: ;
		endcase
	endtask

	// upper data bits are junk the block must mask off
	task automatic configure(input logic [1:0] order, input logic [15:0] length,
	                         input logic [7:0] tcode, input logic uns);
		logic [15:0] junk;
		junk = 16'($urandom);
		write_reg(REG_DELTA_ORDER, {junk[15:2], order});
		write_reg(REG_FRAME_LENGTH, length);
		write_reg(REG_TYPE_BYTE, {junk[7:0], tcode});
		write_reg(REG_UNSIGNED_MODE, {junk[14:0], uns});
		cfg_valid <= 1'b0;
	endtask

	// called at the edge that took the previous word; tvalid only drops for a gap
	task automatic send_sample(input logic [31:0] s);
		int gaps;
		gaps = 0;
		while ($urandom_range(0, 99) < src_idle_pct)
			gaps++;
		if (gaps > 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= $urandom;
			repeat (gaps) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= s;
		do @(posedge clk); while (!s_axis_tready);
		encode_sample(s);
	endtask

	// sender holds off until every predicted word has left the block
	task automatic drain_encoder();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_bytes.size() != 0);
	endtask

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTS)
			$display("MISMATCH @%0t word %0d: %s", $time, out_count, what);
		mismatches++;
	endtask

	// ------------------------------------------------------------------------
	// output side: random stalls, ordered compare
	// ------------------------------------------------------------------------

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
			end else begin
				want = pending_bytes.pop_front();
				if (m_axis_tdata != want.data)
					report_mismatch($sformatf("out_byte %h want %h", m_axis_tdata, want.data));
				if (m_axis_tlast != want.last)
					report_mismatch($sformatf("last_of_run %b want %b", m_axis_tlast, want.last));
				if (m_axis_tuser[0] != want.eof)
					report_mismatch($sformatf("end_of_frame %b want %b", m_axis_tuser[0], want.eof));
				if (m_axis_tuser[1] != want.err)
					report_mismatch($sformatf("range_error %b want %b", m_axis_tuser[1], want.err));
			end
			out_count++;
		end
	end

	// watchdog: a hang shows up as a long stretch with no word moving anywhere
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		run_cycles++;
		if (quiet_cycles >= QUIET_LIMIT || run_cycles >= MAX_RUN_CYCLES) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset config: order 1, one sample per frame, so every sample is a header
	task automatic test_reset_frames();
		send_sample(32'h0000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h8000_0000);
	endtask

	// varints of 1 to 5 bytes, both signs, wrapping delta at the end
	task automatic test_plain_deltas();
		drain_encoder();
		configure(ORDER_PLAIN, 16'd8, 8'hA5, 1'b0);
		send_sample(32'd100);
		send_sample(32'd100);          // zero delta
		send_sample(32'd163);          // +63, one byte
		send_sample(32'd99);           // -64, one byte
		send_sample(32'd163);          // +64, two bytes
		send_sample(32'd8355);         // +8192, three bytes
		send_sample(32'h0010_20A3);    // +1M, four bytes
		send_sample(32'h8010_20A3);    // +2^31, five bytes, closes frame
	endtask

	// raw first delta, then delta of deltas
	task automatic test_delta_of_delta();
		drain_encoder();
		configure(ORDER_DOD, 16'd5, 8'h3C, 1'b0);
		send_sample(32'd10);
		send_sample(32'd20);
		send_sample(32'd30);           // steady slope, dod zero
		send_sample(32'd25);
		send_sample(32'h7FFF_FFFF);
	endtask

	// order code 3 falls back to plain deltas, header keeps the 3
	task automatic test_odd_order();
		drain_encoder();
		configure(ORDER_THREE, 16'd2, 8'hFF, 1'b0);
		send_sample(32'hFFFF_FFF0);
		send_sample(32'h0000_0010);
	endtask

	// unsigned mode: top-bit samples give one error word and restart the frame
	task automatic test_range_errors();
		drain_encoder();
		configure(ORDER_DOD, 16'd4, 8'h00, 1'b1);
		send_sample(32'd5);
		send_sample(32'h8000_0000);    // mid frame
		send_sample(32'h7FFF_FFFF);    // fresh header
		send_sample(32'hFFFF_FFFF);    // right after the header
	endtask

	// length 0 (65536 samples), a lowered length, the top length, a spare index
	task automatic test_length_extremes();
		drain_encoder();
		configure(ORDER_PLAIN, 16'd0, 8'h81, 1'b0);
		send_sample(32'd1);
		send_sample(32'd2);
		drain_encoder();
		write_reg(REG_FRAME_LENGTH, 16'd2);   // position 2 already past it
		cfg_valid <= 1'b0;
		send_sample(32'd3);
		drain_encoder();
		write_reg(REG_FRAME_LENGTH, 16'hFFFF);
		write_reg(REG_FIRST_SPARE + 8'($urandom_range(0, 251)), 16'($urandom));
		cfg_valid <= 1'b0;
		send_sample(32'd4);
	endtask

	// random frames: fresh settings per segment, mostly smooth sample walks
	task automatic test_random_traffic(input int src_pct, input int sink_pct,
	                                   input int segments, input int per_segment);
		logic [31:0] sample;
		logic [31:0] stride;
		logic [1:0]  order;
		logic [15:0] length;
		int          r;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		sample = $urandom;
		for (int seg = 0; seg < segments; seg++) begin
			drain_encoder();
			r = $urandom_range(0, 99);
			if (r < 45)
				order = ORDER_PLAIN;
			else if (r < 90)
				order = ORDER_DOD;
			else
				order = $urandom_range(0, 1) ? ORDER_ZERO : ORDER_THREE;
			r = $urandom_range(0, 99);
			if (r < 55)
				length = 16'($urandom_range(1, 12));
			else if (r < 70)
				length = 16'd1;
			else if (r < 80)
				length = 16'hFFFF;
			else if (r < 88)
				length = 16'd0;
			else
				length = 16'($urandom_range(13, 400));
			configure(order, length, 8'($urandom), ($urandom_range(0, 99) < 30));
			stride = $urandom_range(0, 2000) - 1000;
			for (int k = 0; k < per_segment; k++) begin
				r = $urandom_range(0, 99);
				if (r < 35)
					sample = sample + ($urandom_range(0, 127) - 64);
				else if (r < 55)
					sample = sample + stride;
				else if (r < 70)
					sample = sample + ($urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
				else if (r < 88)
					sample = $urandom;
				else begin
					case ($urandom_range(0, 3))
						0: sample = 32'h0000_0000;
						1: sample = 32'hFFFF_FFFF;
						2: sample = 32'h7FFF_FFFF;
						default: sample = 32'h8000_0000;
					endcase
				end
				// in unsigned mode most samples stay in range
				if (enc_cfg.unsigned_mode && $urandom_range(0, 9) != 0)
					sample[31] = 1'b0;
				send_sample(sample);
			end
		end
	endtask

	initial begin
		enc_cfg        = '{delta_order: ORDER_PLAIN, frame_length: 16'd1,
		                   type_byte: 8'd0, unsigned_mode: 1'b0};
		prev_sample    = '0;
		last_delta     = '0;
		frame_pos      = '0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		mismatches     = 0;
		out_count      = 0;
		quiet_cycles   = 0;
		run_cycles     = 0;
		arst_n         <= 1'b0;
		cfg_valid      <= 1'b0;
		cfg_index      <= '0;
		cfg_data       <= '0;
		s_axis_tvalid  <= 1'b0;
		s_axis_tdata   <= '0;
		m_axis_tready  <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_frames();
		test_plain_deltas();
		test_delta_of_delta();
		test_odd_order();
		test_range_errors();
		test_length_extremes();

		test_random_traffic(0, 0, 4, 28);
		test_random_traffic(73, 0, 4, 28);
		test_random_traffic(0, 73, 4, 28);
		test_random_traffic(23, 23, 4, 28);

		drain_encoder();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_bytes.size() != 0)
			report_mismatch($sformatf("%0d expected words never came", pending_bytes.size()));
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
